// File: hdl/device_address_table_macros.svh
// assertion macros shared by the device address table
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef DEVICE_ADDRESS_TABLE_MACROS_SVH
`define DEVICE_ADDRESS_TABLE_MACROS_SVH

// same-cycle implication, quiet during reset
`define DAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define DAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dat_pkg.sv
// shared types and constants of the device address table
// no dependencies; imported by every module of the block
package dat_pkg;

    // table geometry
    localparam int DAT_CAP    = 255;
    localparam int DAT_PAY_W  = 32;
    localparam int DAT_ADDR_W = 8;
    localparam int DAT_CNT_W  = $clog2(DAT_CAP + 1);

    // ring cell fed back to the tail while a removed entry is skipped
    localparam int DAT_SEC    = (DAT_CAP > 1) ? 1 : 0;

    // free-address map, searched one group of bits per cycle
    localparam int DAT_MAP_W  = 2 ** DAT_ADDR_W;
    localparam int DAT_GRP_W  = 8;
    localparam int DAT_NGRP   = DAT_MAP_W / DAT_GRP_W;
    localparam int DAT_GIDX_W = $clog2(DAT_GRP_W);
    localparam int DAT_GNUM_W = $clog2(DAT_NGRP);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_NO_FREE   = 2'd3
    } t_status;

    // one table entry as held in a cell
    typedef struct packed {
        logic [DAT_ADDR_W-1:0] addr;
        logic [DAT_PAY_W-1:0]  pay;
    } t_entry;

    // controls into the free-address map
    typedef struct packed {
        logic                  clr;
        logic                  set;
        logic [DAT_ADDR_W-1:0] set_addr;
        logic                  step;
    } t_free_cmd;

    // free-address map search status
    typedef struct packed {
        logic                  hit;
        logic                  last;
        logic [DAT_ADDR_W-1:0] addr;
    } t_free_res;

endpackage

// File: hdl/dat_cell.sv
// one storage cell of the entry ring: holds a single table entry
// depends on dat_pkg; loads a new entry or takes its neighbor's entry
module dat_cell import dat_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  logic   i_load,
    input  t_entry i_nxt,
    input  t_entry i_new,
    output t_entry o_ent
);

    t_entry r_ent;
    t_entry n_ent;

    // direct load wins over the ring shift
    always_comb begin
        priority if (i_load) begin
            n_ent = i_new;
        end else if (i_shift) begin
            n_ent = i_nxt;
        end else begin
            n_ent = r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

// File: hdl/dat_free_map.sv
// used-address bitmap and lowest-free-address search
// depends on dat_pkg; built during a ring pass, then shifted out a group per cycle
module dat_free_map import dat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_free_cmd i_cmd,
    output t_free_res o_res
);

    logic [DAT_MAP_W-1:0]  r_map;
    logic [DAT_GNUM_W-1:0] r_grp;
    logic                  w_hit;
    logic [DAT_GIDX_W-1:0] w_idx;

    // group counter gives the high bits of the candidate address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else if (i_cmd.clr) begin
            r_grp <= '0;
        end else if (i_cmd.step) begin
            r_grp <= r_grp + 1'b1;
        end
    end

    // top address is never offered, so it starts out marked used
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_map <= {1'b1, {(DAT_MAP_W-1){1'b0}}};
        end else if (i_cmd.set) begin
            r_map[i_cmd.set_addr] <= 1'b1;
        end else if (i_cmd.step) begin
            r_map <= {{DAT_GRP_W{1'b1}}, r_map[DAT_MAP_W-1:DAT_GRP_W]};
        end
    end

    // lowest clear bit in the current group
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int k = DAT_GRP_W - 1; k >= 0; k--) begin
            if (!r_map[k]) begin
                w_hit = 1'b1;
                w_idx = DAT_GIDX_W'(k);
            end
        end
    end

    assign o_res.hit  = w_hit;
    assign o_res.last = (r_grp == DAT_GNUM_W'(DAT_NGRP - 1));
    assign o_res.addr = {r_grp, w_idx};

endmodule

// File: hdl/device_address_table.sv
// top level of the device address table: controller, entry ring and free map
// depends on dat_pkg, dat_cell, dat_free_map and the assertion macro header
//
// Usage
//   Input channel: i_in_valid / o_in_stall with i_op, i_dev_address, i_dev_payload.
//   Output channel: o_out_valid / i_out_stall with o_status, o_position,
//   o_free_address, o_found_payload. A beat moves when valid is high and stall low.
//   Every input beat gives exactly one output beat, in order; one item is worked
//   on at a time and o_in_stall stays high until its result is in the output register.
//   Entries sit in a ring of 255 cells. Add writes the cell at the fill count and
//   goes through S_ADD and S_DONE to the output register. Remove, lookup and find
//   free rotate the ring once, one cell per cycle, checking the entry at the head;
//   remove closes the gap as the ring turns. Find free then scans a used-address
//   bitmap 8 addresses per cycle until it finds a free address or reaches the last group.
//   The output register frees the controller: a new item is taken while the
//   previous result waits; a stalled receiver holds the result and the next one
//   waits in the controller. Synchronous reset empties the table (count to zero)
//   and drops any pending result; no clearing pass is needed.
`include "device_address_table_macros.svh"

module device_address_table import dat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_dev_address,
    input  logic [31:0] i_dev_payload,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_position,
    output logic [7:0]  o_free_address,
    output logic [31:0] o_found_payload
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_SRCH = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                r_state,      n_state;
    t_op                   r_op,         n_op;
    logic [DAT_ADDR_W-1:0] r_key,        n_key;
    logic [DAT_PAY_W-1:0]  r_pay,        n_pay;
    logic [DAT_CNT_W-1:0]  r_count,      n_count;
    logic [DAT_CNT_W-1:0]  r_step,       n_step;
    logic                  r_found,      n_found;
    t_status               r_res_status, n_res_status;
    logic [DAT_CNT_W-1:0]  r_res_pos,    n_res_pos;
    logic [DAT_ADDR_W-1:0] r_res_free,   n_res_free;
    logic [DAT_PAY_W-1:0]  r_res_pay,    n_res_pay;
    logic                  r_ovld,       n_ovld;
    t_status               r_o_status,   n_o_status;
    logic [DAT_CNT_W-1:0]  r_o_pos,      n_o_pos;
    logic [DAT_ADDR_W-1:0] r_o_free,     n_o_free;
    logic [DAT_PAY_W-1:0]  r_o_pay,      n_o_pay;

    t_entry               w_ent [DAT_CAP];
    t_entry               w_nxt [DAT_CAP];
    logic [DAT_CAP-1:0]   w_load;
    t_entry               w_new;
    t_entry               w_tail;
    logic                 w_shift;
    logic                 w_add_wr;
    logic                 w_head_vld;
    logic                 w_hit;
    logic                 w_del;
    logic                 w_last;
    logic                 w_in_acc;
    logic                 w_out_load;
    t_free_cmd            w_fcmd;
    t_free_res            w_fres;

    // handshake and scan control
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_ovld || !i_out_stall);
    assign w_shift    = (r_state == S_SCAN);
    assign w_add_wr   = (r_state == S_ADD) && (r_count < DAT_CNT_W'(DAT_CAP));
    assign w_head_vld = (r_step < r_count);
    assign w_last     = (r_step == DAT_CNT_W'(DAT_CAP - 1));
    assign w_hit      = w_shift && (r_op == OP_REMOVE || r_op == OP_LOOKUP) && w_head_vld
                        && !r_found && (w_ent[0].addr == r_key);
    assign w_del      = w_shift && (r_op == OP_REMOVE) && (r_found || w_hit);

    // ring feedback: after the removed entry, skip one place
    assign w_new.addr = r_key;
    assign w_new.pay  = r_pay;
    assign w_tail     = w_del ? w_ent[DAT_SEC] : w_ent[0];

    // entry ring
    for (genvar g = 0; g < DAT_CAP; g++) begin : g_cell
        assign w_load[g] = w_add_wr && (r_count == DAT_CNT_W'(g));
        if (g == DAT_CAP - 1) begin : g_tail
            assign w_nxt[g] = w_tail;
        end else begin : g_mid
            assign w_nxt[g] = w_ent[g+1];
        end
        dat_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_load  (w_load[g]),
            .i_nxt   (w_nxt[g]),
            .i_new   (w_new),
            .o_ent   (w_ent[g])
        );
    end

    // used-address map fed from the ring head
    assign w_fcmd.clr      = w_in_acc;
    assign w_fcmd.set      = w_shift && (r_op == OP_FREE) && w_head_vld;
    assign w_fcmd.set_addr = w_ent[0].addr;
    assign w_fcmd.step     = (r_state == S_SRCH);

    dat_free_map u_free_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_fcmd),
        .o_res   (w_fres)
    );

    // controller
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_pay        = r_pay;
        n_count      = r_count;
        n_step       = r_step;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_free   = r_res_free;
        n_res_pay    = r_res_pay;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op         = t_op'(i_op);
                    n_key        = i_dev_address;
                    n_pay        = DAT_PAY_W'(i_dev_payload);
                    n_step       = '0;
                    n_found      = 1'b0;
                    n_res_status = STS_OK;
                    n_res_pos    = '0;
                    n_res_free   = '0;
                    n_res_pay    = '0;
                    n_state      = (t_op'(i_op) == OP_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD: begin
                if (w_add_wr) begin
                    n_res_pos = r_count;
                    n_count   = r_count + 1'b1;
                end else begin
                    n_res_status = STS_FULL;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                n_step = r_step + 1'b1;
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_res_pos = r_step;
                    if (r_op == OP_LOOKUP) begin
                        n_res_pay = w_ent[0].pay;
                    end
                end
                if (w_last) begin
                    n_step = '0;
                    if (r_op == OP_FREE) begin
                        n_state = S_SRCH;
                    end else begin
                        n_state = S_DONE;
                        if (r_found || w_hit) begin
                            if (r_op == OP_REMOVE) begin
                                n_count = r_count - 1'b1;
                            end
                        end else begin
                            n_res_status = STS_NOT_FOUND;
                        end
                    end
                end
            end
            S_SRCH: begin
                if (w_fres.hit) begin
                    n_res_free = w_fres.addr;
                    n_state    = S_DONE;
                end else if (w_fres.last) begin
                    n_res_status = STS_NO_FREE;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ovld     = r_ovld;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_free   = r_o_free;
        n_o_pay    = r_o_pay;
        if (w_out_load) begin
            n_ovld     = 1'b1;
            n_o_status = r_res_status;
            n_o_pos    = r_res_pos;
            n_o_free   = r_res_free;
            n_o_pay    = r_res_pay;
        end else if (!i_out_stall) begin
            n_ovld = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            r_ovld  <= n_ovld;
        end
    end

    // item and result data
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_pay        <= n_pay;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_free   <= n_res_free;
        r_res_pay    <= n_res_pay;
        r_o_status   <= n_o_status;
        r_o_pos      <= n_o_pos;
        r_o_free     <= n_o_free;
        r_o_pay      <= n_o_pay;
    end

    // ports
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovld;
    assign o_status        = r_o_status;
    assign o_position      = 8'(r_o_pos);
    assign o_free_address  = 8'(r_o_free);
    assign o_found_payload = 32'(r_o_pay);

    // checks
    `DAT_ASSERT_NOW(a_idle_step, r_state == S_IDLE, r_step == '0, "ring step not parked at idle")
    `DAT_ASSERT_NEXT(a_add_count, w_add_wr, r_count == $past(r_count) + 1'b1, "add lost count")
    `DAT_ASSERT_NEXT(a_rm_count, w_last && w_del, r_count == $past(r_count) - 1'b1,
        "remove did not shrink table")
    `DAT_ASSERT_NOW(a_out_src, !r_ovld && n_ovld, r_state == S_DONE, "result from wrong state")

endmodule

// File: test/dat_table_checker.sv
`timescale 1ns / 100ps
// result checker for the device address table: watches both channels and keeps its own table
// depends on dat_pkg for the operation and status codes and the table capacity
module dat_table_checker import dat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_dev_address,
    input  logic [31:0] i_dev_payload,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [7:0]  i_position,
    input  logic [7:0]  i_free_address,
    input  logic [31:0] i_found_payload,
    output int          o_mismatch_count,
    output int          o_answers_pending
);

    typedef struct packed {
        t_status     status;
        logic [7:0]  position;
        logic [7:0]  free_address;
        logic [31:0] found_payload;
    } table_reply_t;

    // expected contents of the table, in insertion order
    logic [7:0]   shadow_addr [DAT_CAP];
    logic [31:0]  shadow_pay  [DAT_CAP];
    int           shadow_count;
    table_reply_t expected_replies [$];
    table_reply_t want;
    table_reply_t got;

    initial begin
        o_mismatch_count  = 0;
        o_answers_pending = 0;
        shadow_count      = 0;
    end

    // runs one operation on the expected table and gives the reply it should cause
    function automatic table_reply_t table_answer(t_op op, logic [7:0] addr,
                                                  logic [31:0] pay);
        table_reply_t reply;
        int           hit;
        int           idx;
        logic [255:0] used;
        reply        = '0;
        reply.status = STS_OK;
        hit          = -1;
        used         = '0;
        case (op)
            OP_ADD: begin
                if (shadow_count < DAT_CAP) begin
                    shadow_addr[shadow_count] = addr;
                    shadow_pay[shadow_count]  = pay;
                    reply.position            = 8'(shadow_count);
                    shadow_count++;
                end else begin
                    reply.status = STS_FULL;
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (shadow_addr[idx] == addr) begin
                        hit = idx;
                        break;
                    end
                end
                if (hit < 0) begin
                    reply.status = STS_NOT_FOUND;
                end else begin
                    reply.position = 8'(hit);
                    if (op == OP_LOOKUP) begin
                        reply.found_payload = shadow_pay[hit];
                    end else begin
                        // close the gap left by the removed entry
                        for (idx = hit; idx < shadow_count - 1; idx++) begin
                            shadow_addr[idx] = shadow_addr[idx + 1];
                            shadow_pay[idx]  = shadow_pay[idx + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: begin
                // lowest address below 255 that no entry holds
                for (idx = 0; idx < shadow_count; idx++)
                    used[shadow_addr[idx]] = 1'b1;
                reply.status = STS_NO_FREE;
                for (idx = 0; idx < 255; idx++) begin
                    if (!used[idx]) begin
                        reply.status       = STS_OK;
                        reply.free_address = 8'(idx);
                        break;
                    end
                end
            end
        endcase
        return reply;
    endfunction

    // result beats are checked before the input beat of the same edge is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.status        = t_status'(i_status);
                got.position      = i_position;
                got.free_address  = i_free_address;
                got.found_payload = i_found_payload;
                if (expected_replies.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %0d",
                             $time, got.status);
                    o_mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        o_mismatch_count++;
                    end
                    if (got.position !== want.position) begin
                        $display("%0t: position expected %0d got %0d",
                                 $time, want.position, got.position);
                        o_mismatch_count++;
                    end
                    if (got.free_address !== want.free_address) begin
                        $display("%0t: free address expected %0d got %0d",
                                 $time, want.free_address, got.free_address);
                        o_mismatch_count++;
                    end
                    if (got.found_payload !== want.found_payload) begin
                        $display("%0t: payload expected %h got %h",
                                 $time, want.found_payload, got.found_payload);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_replies.push_back(table_answer(t_op'(i_op), i_dev_address,
                                                        i_dev_payload));
        end
        o_answers_pending = expected_replies.size();
    end

endmodule

// File: test/tb_device_address_table.sv
`timescale 1ns / 100ps
// testbench top for the device address table: clock, reset, stimulus and verdict
// depends on dat_pkg, device_address_table and dat_table_checker
module tb_device_address_table;
    import dat_pkg::*;

    localparam int ITEMS_TARGET    = 1500;
    localparam int HOLD_OFF_START  = 300;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 400;
    localparam int CYCLE_LIMIT     = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [7:0]  i_dev_address;
    logic [31:0] i_dev_payload;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [7:0]  o_position;
    logic [7:0]  o_free_address;
    logic [31:0] o_found_payload;

    int          mismatch_count;
    int          answers_pending;
    int          sent_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;
    // addresses the table should hold, used only to shape the stimulus
    logic [7:0]  table_addrs [$];

    always #10 i_clk = ~i_clk;

    device_address_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_dev_address   (i_dev_address),
        .i_dev_payload   (i_dev_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_free_address  (o_free_address),
        .o_found_payload (o_found_payload)
    );

    dat_table_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_dev_address     (i_dev_address),
        .i_dev_payload     (i_dev_payload),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_position        (o_position),
        .i_free_address    (o_free_address),
        .i_found_payload   (o_found_payload),
        .o_mismatch_count  (mismatch_count),
        .o_answers_pending (answers_pending)
    );

    // offers one beat and waits until it is taken; idling follows the current phase
    task automatic send_item(input t_op op, input logic [7:0] addr, input logic [31:0] pay);
        int idx;
        case ((sent_count / 150) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_dev_address <= addr;
        i_dev_payload <= pay;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
        if (op == OP_ADD && table_addrs.size() < DAT_CAP) begin
            table_addrs.push_back(addr);
        end else if (op == OP_REMOVE) begin
            for (idx = 0; idx < table_addrs.size(); idx++) begin
                if (table_addrs[idx] == addr) begin
                    table_addrs.delete(idx);
                    break;
                end
            end
        end
    endtask

    // removes every entry in random order, then probes the empty table
    task automatic drain_table();
        while (table_addrs.size() > 0)
            send_item(OP_REMOVE, table_addrs[$urandom_range(table_addrs.size() - 1)],
                      $urandom);
        send_item(OP_FREE, 8'($urandom_range(255)), $urandom);
        send_item(OP_REMOVE, 8'($urandom_range(255)), $urandom);
        send_item(OP_LOOKUP, 8'($urandom_range(255)), $urandom);
    endtask

    // fills the table with every address below 255, hits the full cases, then thins it out
    task automatic fill_table();
        logic [7:0] order [$];
        logic [7:0] swap;
        logic [7:0] gone;
        int         idx;
        int         pick;
        drain_table();
        for (idx = 0; idx < 255; idx++)
            order.push_back(8'(idx));
        for (idx = 254; idx > 0; idx--) begin
            pick        = $urandom_range(idx);
            swap        = order[idx];
            order[idx]  = order[pick];
            order[pick] = swap;
        end
        for (idx = 0; idx < 255; idx++)
            send_item(OP_ADD, order[idx], $urandom);
        send_item(OP_FREE, 8'($urandom_range(255)), $urandom);
        send_item(OP_ADD, 8'($urandom_range(255)), $urandom);
        send_item(OP_LOOKUP, 8'($urandom_range(254)), $urandom);
        gone = 8'($urandom_range(254));
        send_item(OP_REMOVE, gone, $urandom);
        send_item(OP_FREE, 8'($urandom_range(255)), $urandom);
        send_item(OP_ADD, gone, $urandom);
        repeat ($urandom_range(10, 40))
            send_item(OP_REMOVE, table_addrs[$urandom_range(table_addrs.size() - 1)],
                      $urandom);
    endtask

    // random mix of operations, half of them aimed at addresses the table holds
    task automatic mixed_items(input int count);
        int         sel;
        t_op        op;
        logic [7:0] addr;
        logic [31:0] pay;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 35)      op = OP_ADD;
            else if (sel < 55) op = OP_REMOVE;
            else if (sel < 80) op = OP_LOOKUP;
            else               op = OP_FREE;
            if (table_addrs.size() > 0 && $urandom_range(1))
                addr = table_addrs[$urandom_range(table_addrs.size() - 1)];
            else
                addr = 8'($urandom_range(255));
            case ($urandom_range(9))
                0:       pay = '0;
                1:       pay = '1;
                default: pay = $urandom;
            endcase
            send_item(op, addr, pay);
        end
    endtask

    // result side: random stall per phase, plus one long hold-off to back up the block
    initial begin
        int hold_cnt;
        bit hold_done;
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count >= HOLD_OFF_START) begin
                i_out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_OFF_CYCLES; hold_cnt++)
                    @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // reset, directed items, random rounds, then the verdict
    initial begin
        int round;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_ADD;
        i_dev_address = '0;
        i_dev_payload = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, duplicates and compaction
        send_item(OP_FREE,   8'h00, 32'h0000_0000);
        send_item(OP_REMOVE, 8'h00, 32'h0000_0000);
        send_item(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF);
        send_item(OP_ADD,    8'h00, 32'h0000_0000);
        send_item(OP_ADD,    8'hFF, 32'hFFFF_FFFF);
        send_item(OP_ADD,    8'h00, 32'hA5A5_A5A5);
        send_item(OP_ADD,    8'h01, 32'h5A5A_5A5A);
        send_item(OP_LOOKUP, 8'h00, 32'h0000_0000);
        send_item(OP_LOOKUP, 8'hFF, 32'h0000_0000);
        send_item(OP_FREE,   8'hFF, 32'h0000_0000);
        send_item(OP_REMOVE, 8'h00, 32'h0000_0000);
        send_item(OP_LOOKUP, 8'h00, 32'h0000_0000);
        send_item(OP_LOOKUP, 8'h01, 32'h0000_0000);
        send_item(OP_REMOVE, 8'h7E, 32'h0000_0000);
        send_item(OP_REMOVE, 8'hFF, 32'h0000_0000);
        send_item(OP_REMOVE, 8'h00, 32'h0000_0000);
        send_item(OP_REMOVE, 8'h01, 32'h0000_0000);
        send_item(OP_FREE,   8'h00, 32'h0000_0000);

        round = 0;
        while (sent_count < ITEMS_TARGET) begin
            case (round % 10)
                1:       fill_table();
                7:       drain_table();
                default: mixed_items($urandom_range(20, 60));
            endcase
            round++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (answers_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && answers_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: device_address_table.f
+incdir+hdl
hdl/dat_pkg.sv
hdl/dat_cell.sv
hdl/dat_free_map.sv
hdl/device_address_table.sv
test/dat_table_checker.sv
test/tb_device_address_table.sv
